>>> design/jetcm_pkg.sv
package jetcm_pkg;

  // Data formats
  localparam int SAMPLE_W            = 32;
  localparam int REG_W               = 32;
  localparam int CHAN_W              = 8;
  localparam int ENTRY_W             = 5;   // table entries in sixteenths, 0..16
  localparam int COLOR_ENTRIES       = 64;
  localparam int SCALE_FRACTION_BITS = 24;
  localparam int TABLE_ROWS          = 64;
  localparam int ROW_W               = 6;
  localparam int FRAC_BITS           = 24;
  localparam int NUM_CHANNELS        = 3;

  // Product of the difference and the scale: 16 + SCALE_FRACTION_BITS fraction bits
  localparam int PROD_W  = 2 * SAMPLE_W;
  localparam int POS_LSB = 16 + SCALE_FRACTION_BITS - FRAC_BITS;
  localparam int POS_W   = PROD_W - POS_LSB;
  localparam int IPART_W = POS_W - FRAC_BITS;

  localparam int ROW_LIMIT =
    ((COLOR_ENTRIES < TABLE_ROWS) ? COLOR_ENTRIES : TABLE_ROWS) - 2;

  // Blend sum c = a*(1 - f) + b*f, at most 16 * 2^24
  localparam int BLEND_W = ENTRY_W + FRAC_BITS;
  localparam int SCALED_W = BLEND_W + CHAN_W;

  localparam logic [CHAN_W-1:0] GREY_LEVEL = CHAN_W'(204);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION_SCALE = 2'd2;

  localparam logic [REG_W-1:0] MIN_VALUE_RESET      = 32'd0;
  localparam logic [REG_W-1:0] MAX_VALUE_RESET      = 32'd65536;
  localparam logic [REG_W-1:0] POSITION_SCALE_RESET = 32'd1056964608;

  typedef struct packed {
    logic signed [REG_W-1:0] min_value;
    logic signed [REG_W-1:0] max_value;
    logic [REG_W-1:0]        position_scale;
  } cfg_regs_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] r;
    logic [ENTRY_W-1:0] g;
    logic [ENTRY_W-1:0] b;
  } jet_row_t;

  // Jet table in sixteenths, built from its piecewise-linear segments
  function automatic jet_row_t jet_entry(input logic [ROW_W-1:0] i);
    jet_row_t e;
    e = '0;
    priority if (i < 6'd8) begin
      e.b = ENTRY_W'(i + 6'd9);
    end else if (i < 6'd24) begin
      e.g = ENTRY_W'(i - 6'd7);
      e.b = ENTRY_W'(16);
    end else if (i < 6'd40) begin
      e.r = ENTRY_W'(i - 6'd23);
      e.g = ENTRY_W'(16);
      e.b = ENTRY_W'(6'd39 - i);
    end else if (i < 6'd56) begin
      e.r = ENTRY_W'(16);
      e.g = ENTRY_W'(6'd55 - i);
    end else begin
      e.r = ENTRY_W'(7'd71 - {1'b0, i});
    end
    return e;
  endfunction

endpackage

>>> design/jetcm_cfg.sv
module jetcm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jetcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jetcm_pkg::REG_W-1:0]         cfg_wdata,
  output jetcm_pkg::cfg_regs_t                regs
);
  import jetcm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_value      <= MIN_VALUE_RESET;
      regs.max_value      <= MAX_VALUE_RESET;
      regs.position_scale <= POSITION_SCALE_RESET;
    end else if (cfg_we) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_index)
        REG_MIN_VALUE:      regs.min_value      <= cfg_wdata;
        REG_MAX_VALUE:      regs.max_value      <= cfg_wdata;
        REG_POSITION_SCALE: regs.position_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> design/jet_colormap_pseudocolor.sv
// Jet pseudocolor mapper. Each signed Q16.16 sample on the slave stream becomes
// one RGB pixel on the master stream, in order. A sample below min_value or
// above max_value gives grey 204,204,204 with the out-of-range flag set in
// tuser. Otherwise the position (sample - min_value) * position_scale picks two
// neighboring entries of a 64-entry jet table and blends them with a 24-bit
// fraction; positions past the last section give the last entry. Software sets
// position_scale to 63 / (max_value - min_value) in unsigned Q8.24. Registers
// must be written through the cfg port only while the stream is idle; the block
// does not enforce this. Throughput is one request per clock while the output is
// not stalled. Stages: range check, 32x32 multiply, table lookup, blend, scale
// and round. Each stage holds its request while the stage after it is full and
// stalled, so bubbles are squeezed out and input is taken while a result waits.
module jet_colormap_pseudocolor (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [jetcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jetcm_pkg::REG_W-1:0]         cfg_wdata,
  // sample stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,   // [31:0] sample_value
  // pixel stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // [7:0] red, [15:8] green,
                                                              // [23:16] blue
  output logic                                m_axis_tuser    // [0] out_of_range
);
  import jetcm_pkg::*;

  cfg_regs_t regs;

  jetcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // Stage handshake: a stage loads when it is empty or its content moves on
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  assign out_ready     = !out_valid || m_axis_tready;
  assign s4_ready      = !s4_valid  || out_ready;
  assign s3_ready      = !s3_valid  || s4_ready;
  assign s2_ready      = !s2_valid  || s3_ready;
  assign s1_ready      = !s1_valid  || s2_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid  <= s_axis_tvalid;
      if (s2_ready)  s2_valid  <= s1_valid;
      if (s3_ready)  s3_valid  <= s2_valid;
      if (s4_ready)  s4_valid  <= s3_valid;
      if (out_ready) out_valid <= s4_valid;
    end
  end

  // Stage 1: range check and offset from min_value
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W:0]   offset_next;
  logic                       oor_next;
  logic [SAMPLE_W-1:0]        s1_diff;
  logic                       s1_oor;

  assign sample      = s_axis_tdata;
  assign offset_next = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(regs.min_value);
  assign oor_next    = offset_next[SAMPLE_W] || (sample > regs.max_value);

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_diff <= offset_next[SAMPLE_W-1:0];
      s1_oor  <= oor_next;
    end
  end

  // Stage 2: table position = difference * scale, keep integer part and fraction
  logic [PROD_W-1:0] product_next;
  logic [POS_W-1:0]  s2_pos;
  logic              s2_oor;

  assign product_next = PROD_W'(s1_diff) * PROD_W'(regs.position_scale);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_pos <= product_next[PROD_W-1:POS_LSB];
      s2_oor <= s1_oor;
    end
  end

  // Stage 3: saturate the position at the last section, fetch both neighbors
  logic [IPART_W-1:0]   ipart;
  logic                 past_end;
  logic [ROW_W-1:0]     row_next;
  logic [FRAC_BITS:0]   frac_next;
  jet_row_t             lo_row, hi_row;
  logic [ENTRY_W-1:0]   s3_lo [NUM_CHANNELS];
  logic [ENTRY_W-1:0]   s3_hi [NUM_CHANNELS];
  logic [FRAC_BITS:0]   s3_frac;
  logic                 s3_oor;

  assign ipart    = s2_pos[POS_W-1:FRAC_BITS];
  assign past_end = ipart > IPART_W'(ROW_LIMIT);

  always_comb begin
    if (past_end) begin
      row_next  = ROW_W'(ROW_LIMIT);
      frac_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      row_next  = ipart[ROW_W-1:0];
      frac_next = {1'b0, s2_pos[FRAC_BITS-1:0]};
    end
  end

  assign lo_row = jet_entry(row_next);
  assign hi_row = jet_entry(row_next + ROW_W'(1));

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_lo[0] <= lo_row.r;
      s3_lo[1] <= lo_row.g;
      s3_lo[2] <= lo_row.b;
      s3_hi[0] <= hi_row.r;
      s3_hi[1] <= hi_row.g;
      s3_hi[2] <= hi_row.b;
      s3_frac  <= frac_next;
      s3_oor   <= s2_oor;
    end
  end

  // Stage 4: blend per channel as a + (b - a) * f, in 2^-24 sixteenths
  logic signed [ENTRY_W:0]    delta  [NUM_CHANNELS];
  logic signed [31:0]         slope  [NUM_CHANNELS];
  logic signed [31:0]         base   [NUM_CHANNELS];
  logic signed [FRAC_BITS+1:0] frac_s;
  logic [BLEND_W-1:0]         blend_next [NUM_CHANNELS];
  logic [BLEND_W-1:0]         s4_blend   [NUM_CHANNELS];
  logic                       s4_oor;

  assign frac_s = {1'b0, s3_frac};

  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      delta[ch] = $signed({1'b0, s3_hi[ch]}) - $signed({1'b0, s3_lo[ch]});
      slope[ch] = 32'(delta[ch]) * 32'(frac_s);
      base[ch]  = $signed({3'b0, s3_lo[ch], {FRAC_BITS{1'b0}}});
      blend_next[ch] = BLEND_W'(base[ch] + slope[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        s4_blend[ch] <= blend_next[ch];
      end
      s4_oor <= s3_oor;
    end
  end

  // Stage 5: times 255, round half up to 8 bits, or grey when out of range
  localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1) << (BLEND_W - 2);

  logic [SCALED_W-1:0] scaled  [NUM_CHANNELS];
  logic [CHAN_W-1:0]   chan_next [NUM_CHANNELS];
  logic [CHAN_W-1:0]   out_chan [NUM_CHANNELS];
  logic                out_oor;

  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      scaled[ch] = ({s4_blend[ch], {CHAN_W{1'b0}}} - SCALED_W'(s4_blend[ch])) + ROUND_HALF;
      chan_next[ch] = s4_oor ? GREY_LEVEL : scaled[ch][BLEND_W+CHAN_W-2:BLEND_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        out_chan[ch] <= chan_next[ch];
      end
      out_oor <= s4_oor;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_chan[2], out_chan[1], out_chan[0]};
  assign m_axis_tuser  = out_oor;

endmodule

>>> sim/jetcm_checker.sv
`timescale 1ns / 1ps

module jetcm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [jetcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jetcm_pkg::REG_W-1:0]       cfg_wdata,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // [31:0] sample_value
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [23:0]                       m_axis_tdata,   // [7:0] red, [15:8] green,
                                                            // [23:16] blue
  input  logic                              m_axis_tuser,   // [0] out_of_range
  output int                                mismatches,
  output int                                pending,
  output int                                pixels_checked,
  output int                                grey_pixels
);
  import jetcm_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              out_of_range;
  } pixel_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    pixel_t              pix;
  } pixel_expect_t;

  // Jet levels in sixteenths: red, green, blue rows
  localparam int JET_LEVEL [3][64] = '{
    '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
       0,  0,  0,  0,  0,  0,  0,  0,  1,  2,  3,  4,  5,  6,  7,  8,
       9, 10, 11, 12, 13, 14, 15, 16, 16, 16, 16, 16, 16, 16, 16, 16,
      16, 16, 16, 16, 16, 16, 16, 16, 15, 14, 13, 12, 11, 10,  9,  8},
    '{ 0,  0,  0,  0,  0,  0,  0,  0,  1,  2,  3,  4,  5,  6,  7,  8,
       9, 10, 11, 12, 13, 14, 15, 16, 16, 16, 16, 16, 16, 16, 16, 16,
      16, 16, 16, 16, 16, 16, 16, 16, 15, 14, 13, 12, 11, 10,  9,  8,
       7,  6,  5,  4,  3,  2,  1,  0,  0,  0,  0,  0,  0,  0,  0,  0},
    '{ 9, 10, 11, 12, 13, 14, 15, 16, 16, 16, 16, 16, 16, 16, 16, 16,
      16, 16, 16, 16, 16, 16, 16, 16, 15, 14, 13, 12, 11, 10,  9,  8,
       7,  6,  5,  4,  3,  2,  1,  0,  0,  0,  0,  0,  0,  0,  0,  0,
       0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0}
  };

  logic signed [REG_W-1:0] range_lo;
  logic signed [REG_W-1:0] range_hi;
  logic [REG_W-1:0]        pos_scale;
  pixel_expect_t           owed_pixels [$];
  int                      fail_total;
  int                      checked_total;
  int                      grey_total;

  function automatic pixel_t map_to_jet(input logic signed [31:0] sample,
                                        input logic signed [31:0] lo,
                                        input logic signed [31:0] hi,
                                        input logic [31:0]        scale);
    pixel_t      px;
    logic [32:0] diff;
    logic [63:0] prod;
    logic [23:0] ipart;
    logic [24:0] frac;
    logic [63:0] acc;
    int          row;
    px = '0;
    if (sample < lo || sample > hi) begin
      px.red          = GREY_LEVEL;
      px.green        = GREY_LEVEL;
      px.blue         = GREY_LEVEL;
      px.out_of_range = 1'b1;
      return px;
    end
    diff  = {sample[31], sample} - {lo[31], lo};
    prod  = 64'(diff[31:0]) * 64'(scale);
    ipart = prod[63:40];
    frac  = {1'b0, prod[39:16]};
    // past the last section: pin to the final entry
    if (ipart > ROW_LIMIT) begin
      row  = ROW_LIMIT;
      frac = 25'h1000000;
    end else begin
      row = int'(ipart);
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 64'(JET_LEVEL[ch][row]) * ((64'd1 << FRAC_BITS) - 64'(frac))
          + 64'(JET_LEVEL[ch][row + 1]) * 64'(frac);
      acc = (acc * 64'd255 + (64'd1 << 27)) >> 28;
      case (ch)
        0:       px.red   = acc[7:0];
        1:       px.green = acc[7:0];
        default: px.blue  = acc[7:0];
      endcase
    end
    return px;
  endfunction

  always @(posedge clk) begin : watch
    pixel_expect_t want;
    pixel_t        got;
    if (rst) begin
      owed_pixels.delete();
      range_lo      = MIN_VALUE_RESET;
      range_hi      = MAX_VALUE_RESET;
      pos_scale     = POSITION_SCALE_RESET;
      fail_total    = 0;
      checked_total = 0;
      grey_total    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_VALUE:      range_lo  = cfg_wdata;
          REG_MAX_VALUE:      range_hi  = cfg_wdata;
          REG_POSITION_SCALE: pos_scale = cfg_wdata;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want.sample = s_axis_tdata;
        want.pix    = map_to_jet(s_axis_tdata, range_lo, range_hi, pos_scale);
        owed_pixels.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.red          = m_axis_tdata[7:0];
        got.green        = m_axis_tdata[15:8];
        got.blue         = m_axis_tdata[23:16];
        got.out_of_range = m_axis_tuser;
        if (owed_pixels.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("[%0t] unexpected pixel r=%0d g=%0d b=%0d oor=%0b", $realtime,
                     got.red, got.green, got.blue, got.out_of_range);
        end else begin
          want = owed_pixels.pop_front();
          checked_total++;
          if (want.pix.out_of_range) grey_total++;
          if (got !== want.pix) begin
            fail_total++;
            if (fail_total <= 10)
              $display("[%0t] sample %0d: expected r=%0d g=%0d b=%0d oor=%0b,",
                       $realtime, $signed(want.sample),
                       want.pix.red, want.pix.green, want.pix.blue, want.pix.out_of_range,
                       " got r=%0d g=%0d b=%0d oor=%0b",
                       got.red, got.green, got.blue, got.out_of_range);
          end
        end
      end
    end
    pending        <= owed_pixels.size();
    mismatches     <= fail_total;
    pixels_checked <= checked_total;
    grey_pixels    <= grey_total;
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import jetcm_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int TAIL_CYCLES      = 16;     // a few times the depth of the five-stage pipeline

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = REG_MIN_VALUE;
  logic [REG_W-1:0]       cfg_wdata     = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;
  logic                   m_axis_tuser;

  int       mismatches;
  int       pending;
  int       pixels_checked;
  int       grey_pixels;
  int       cycle_count   = 0;
  int       burst_left    = 0;
  int       range_setups  = 1;
  longint   cur_lo        = 0;
  longint   cur_hi        = 65536;
  rx_mode_t rx_mode       = RX_STREAM;
  int       rx_mode_left  = 0;
  int       rx_tick       = 0;

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  jet_colormap_pseudocolor DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  jetcm_checker pixel_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatches     (mismatches),
    .pending        (pending),
    .pixels_checked (pixels_checked),
    .grey_pixels    (grey_pixels)
  );

  // Pixel sink back-pressure: hop between a few stall patterns, each held for a
  // random stretch, so stalls land on every pipeline stage and full-rate runs
  // still occur.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM:   m_axis_tready <= 1'b1;
        RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 4) == 0);
        RX_PERIODIC: m_axis_tready <= (rx_tick % 7) > 2;
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Hard stop if the handshakes hang.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // Issue one sample request, opening a random gap first whenever the current
  // burst is used up, then hold it until the mapper takes it.
  task automatic send_sample(input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and hold off until every owed pixel has come back. The checker
  // updates its counts at the clock edge, so at least one edge passes first.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Load a new display range; only called with the pipeline empty.
  task automatic set_range(input longint lo, input longint hi, input logic [31:0] scale);
    write_reg(REG_MIN_VALUE, 32'(lo));
    write_reg(REG_MAX_VALUE, 32'(hi));
    write_reg(REG_POSITION_SCALE, scale);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
    range_setups++;
  endtask

  // Matching scale for a range: 63 / width in Q8.24, with the width in Q16.16.
  function automatic logic [31:0] scale_for(input longint lo, input longint hi);
    longint quot;
    if (hi <= lo) return '1;
    quot = (longint'(63) << 40) / (hi - lo);
    return (quot > 64'sh0_FFFF_FFFF) ? '1 : 32'(quot);
  endfunction

  // Mostly in-range samples, some right at the range edges, the rest any 32-bit
  // pattern so every bit toggles.
  function automatic logic [31:0] pick_sample(input longint lo, input longint hi);
    int              pick;
    longint unsigned span;
    longint unsigned roll;
    pick = $urandom_range(0, 99);
    if (pick < 70 && lo <= hi) begin
      span = longint'(hi - lo + 1);
      roll = {$urandom, $urandom};
      return 32'(lo + longint'(roll % span));
    end
    if (pick < 85) begin
      case ($urandom_range(0, 5))
        0:       return 32'(lo);
        1:       return 32'(lo - 1);
        2:       return 32'(lo + 1);
        3:       return 32'(hi);
        4:       return 32'(hi - 1);
        default: return 32'(hi + 1);
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_samples(input int count);
    repeat (count) send_sample(pick_sample(cur_lo, cur_hi));
  endtask

  initial begin : stimulus
    logic [31:0] corners [17];
    longint      lo;
    longint      hi;
    // Reset range is [0, 1.0] with the matching scale: hit both ends, just
    // outside them, the signed extremes, section borders, the last section and the
    // top end of 1.0, where the position saturates onto the final table entry.
    corners = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
                32'h0001_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0000_8000, 32'd1040,      32'd1041,      32'd64496,
                32'd64497,     32'd64528,     32'hFFFF_0000, 32'h0000_4000,
                32'h0000_C000};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (corners[i]) send_sample(corners[i]);
    random_samples(RANDOM_PER_PHASE);
    drain();

    // widest range the format allows
    set_range(-64'sd2147483648, 64'sd2147483647,
              scale_for(-64'sd2147483648, 64'sd2147483647));
    random_samples(RANDOM_PER_PHASE);
    drain();

    // random range, matching scale
    lo = longint'($urandom_range(0, 2000000)) - 1000000;
    hi = lo + $urandom_range(16128, 3000000);
    set_range(lo, hi, scale_for(lo, hi));
    random_samples(RANDOM_PER_PHASE);
    drain();

    // range of width zero: only the one value maps, full-scale multiplier
    lo = longint'($urandom_range(0, 400000)) - 200000;
    set_range(lo, lo, '1);
    random_samples(RANDOM_PER_PHASE);
    drain();

    // reversed range: everything goes grey
    set_range(5 * 65536, -5 * 65536, $urandom);
    random_samples(RANDOM_PER_PHASE);
    drain();

    // zero scale: every in-range sample lands on the first entry
    lo = longint'($urandom_range(0, 2000000)) - 1000000;
    hi = lo + $urandom_range(1, 3000000);
    set_range(lo, hi, '0);
    random_samples(RANDOM_PER_PHASE);
    drain();

    // scale unrelated to the range, mostly saturating
    lo = longint'($urandom_range(0, 2000000)) - 1000000;
    hi = lo + $urandom_range(1, 3000000);
    set_range(lo, hi, $urandom);
    random_samples(RANDOM_PER_PHASE);
    drain();

    // [-1.0, 1.0] with a slightly oversized scale to graze the saturation point
    set_range(-65536, 65536, scale_for(-65536, 65536) + $urandom_range(0, 4096));
    random_samples(RANDOM_PER_PHASE);
    drain();

    // let any stray pixel surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d pixels over %0d range settings, %0d of them grey",
             pixels_checked, range_setups, grey_pixels);
    $display("mismatching pixels: %0d, pixels still owed: %0d", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> jet_colormap_pseudocolor.f
design/jetcm_pkg.sv
design/jetcm_cfg.sv
design/jet_colormap_pseudocolor.sv
sim/jetcm_checker.sv
sim/testbench.sv
